### hdl/gced_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gced_pkg
// Shared types and constants for the gamepad control event detector.
// ----------------------------------------------------------------------------
package gced_pkg;

    localparam int AXIS_COUNT = 8;
    localparam int AXIS_W     = 16;
    localparam int HAT_W      = 16;
    localparam int KIND_W     = 2;
    localparam int INDEX_W    = 6;
    localparam int DIR_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int BTN_CNT_W  = 7;
    localparam int HAT_CNT_W  = 3;
    localparam int BAND_W     = 15;
    localparam int IN_DATA_W  = 256;
    localparam int OUT_DATA_W = 8;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HAT    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_AXIS   = 2'd3;

    // directions
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;
    localparam logic [DIR_W-1:0] DIR_PLUS  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_MINUS = 2'd1;

    // hat angles, hundredths of a degree
    localparam logic [HAT_W-1:0] ANG_UP    = 16'd0;
    localparam logic [HAT_W-1:0] ANG_RIGHT = 16'd9000;
    localparam logic [HAT_W-1:0] ANG_DOWN  = 16'd18000;
    localparam logic [HAT_W-1:0] ANG_LEFT  = 16'd27000;

    // register reset values
    localparam logic [AXIS_W-1:0] CENTER_RST = 16'h7fff;
    localparam logic [BAND_W-1:0] BAND_RST   = 15'h1000;
    localparam logic [BAND_W-1:0] TRIP_RST   = 15'h4000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUTTON_COUNT  = 3'd0,
        CFG_HAT_COUNT     = 3'd1,
        CFG_AXIS_CENTER   = 3'd2,
        CFG_REARM_BAND    = 3'd3,
        CFG_TRIP_DISTANCE = 3'd4
    } t_cfg_idx;

endpackage : gced_pkg
`default_nettype wire

### hdl/gamepad_control_event_detector_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_control_event_detector_top
// An input beat is registered in the input reg, then in the result reg, and leaves as a result beat.
// Throughput: one beat per cycle while m_axis_tready does not stall; one result beat per input beat.
// Rate is set by the single-pass decode of button/hat/axis priority.
// Reset (sync, active low) clears valids, arm flags and counts, and loads center, band and trip defaults.
// ----------------------------------------------------------------------------
module gamepad_control_event_detector_top #(
    parameter int MAX_BUTTONS = 64,
    parameter int MAX_HATS    = 4
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // config write channel
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [gced_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [gced_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // sample stream
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [63:0] button_bits, [127:64] hat_angles, [143:128] axis_x,
    // [159:144] axis_y, [175:160] axis_z, [191:176] axis_rx,
    // [207:192] axis_ry, [223:208] axis_rz, [239:224] slider_one,
    // [255:240] slider_two
    input  wire logic [gced_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [0] sample_valid
    input  wire logic                                 s_axis_tuser,
    // event stream
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [5:0] event_index, [7:6] event_direction
    output logic [gced_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
    // [1:0] event_kind
    output logic [gced_pkg::KIND_W-1:0]               m_axis_tuser
);
    import gced_pkg::*;

    // config registers
    logic [BTN_CNT_W-1:0] r_button_count;
    logic [HAT_CNT_W-1:0] r_hat_count;
    logic [AXIS_W-1:0]    r_axis_center;
    logic [BAND_W-1:0]    r_rearm_band;
    logic [BAND_W-1:0]    r_trip_distance;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_button_count  <= '0;
            r_hat_count     <= '0;
            r_axis_center   <= CENTER_RST;
            r_rearm_band    <= BAND_RST;
            r_trip_distance <= TRIP_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BUTTON_COUNT:  r_button_count  <= i_cfg_data[BTN_CNT_W-1:0];
                CFG_HAT_COUNT:     r_hat_count     <= i_cfg_data[HAT_CNT_W-1:0];
                CFG_AXIS_CENTER:   r_axis_center   <= i_cfg_data[AXIS_W-1:0];
                CFG_REARM_BAND:    r_rearm_band    <= i_cfg_data[BAND_W-1:0];
                CFG_TRIP_DISTANCE: r_trip_distance <= i_cfg_data[BAND_W-1:0];
                default: ;
            endcase
        end
    end

    // input register stage
    logic                         r_in_vld;
    logic                         r_in_sv;
    logic [MAX_BUTTONS-1:0]       r_btn;
    logic [MAX_HATS*HAT_W-1:0]    r_hat;
    logic [AXIS_W-1:0]            r_axis [AXIS_COUNT];

    // result register stage
    logic                         r_out_vld;
    logic [KIND_W-1:0]            r_out_kind;
    logic [INDEX_W-1:0]           r_out_index;
    logic [DIR_W-1:0]             r_out_dir;
    logic [AXIS_COUNT-1:0]        r_armed;

    logic adv;
    assign adv           = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_sv <= s_axis_tuser;
            r_btn   <= s_axis_tdata[MAX_BUTTONS-1:0];
            r_hat   <= s_axis_tdata[64 +: MAX_HATS*HAT_W];
            for (int a = 0; a < AXIS_COUNT; a++) begin
                r_axis[a] <= s_axis_tdata[128 + AXIS_W*a +: AXIS_W];
            end
        end
    end

    // buttons: lowest pressed among the configured count
    logic [MAX_BUTTONS-1:0] btn_m;
    logic [MAX_BUTTONS-1:0] btn_lsb;
    logic                   btn_hit;
    logic [INDEX_W-1:0]     btn_idx;

    always_comb begin
        btn_idx = '0;
        for (int i = 0; i < MAX_BUTTONS; i++) begin
            btn_m[i] = r_btn[i] && (BTN_CNT_W'(i) < r_button_count);
        end
        btn_lsb = btn_m & (-btn_m);
        btn_hit = |btn_m;
        for (int i = 0; i < MAX_BUTTONS; i++) begin
            if (btn_lsb[i]) begin
                btn_idx = btn_idx | INDEX_W'(i);
            end
        end
    end

    // hats: first one sitting exactly on a cardinal direction
    logic               hat_hit;
    logic [INDEX_W-1:0] hat_idx;
    logic [DIR_W-1:0]   hat_dir;
    logic [HAT_W-1:0]   ang;

    always_comb begin
        hat_hit = 1'b0;
        hat_idx = '0;
        hat_dir = DIR_UP;
        ang     = '0;
        for (int i = 0; i < MAX_HATS; i++) begin
            ang = r_hat[HAT_W*i +: HAT_W];
            if (!hat_hit && (HAT_CNT_W'(i) < r_hat_count)) begin
                if (ang == ANG_UP || ang == ANG_RIGHT || ang == ANG_DOWN ||
                    ang == ANG_LEFT) begin
                    hat_hit = 1'b1;
                    hat_idx = INDEX_W'(i);
                    if (ang == ANG_UP)         hat_dir = DIR_UP;
                    else if (ang == ANG_RIGHT) hat_dir = DIR_RIGHT;
                    else if (ang == ANG_DOWN)  hat_dir = DIR_DOWN;
                    else                       hat_dir = DIR_LEFT;
                end
            end
        end
    end

    // axes: hysteresis compares, all on unsigned 17-bit sums so no negatives
    logic [AXIS_W:0]       c_plus_band;
    logic [AXIS_W:0]       c_plus_trip;
    logic [AXIS_W:0]       v_plus_band;
    logic [AXIS_W:0]       v_plus_trip;
    logic [AXIS_W:0]       v_ext;
    logic                  arm_now;
    logic                  ax_hit;
    logic [INDEX_W-1:0]    ax_idx;
    logic [DIR_W-1:0]      ax_dir;
    logic [AXIS_COUNT-1:0] ax_armed;

    always_comb begin
        c_plus_band = {1'b0, r_axis_center} + {2'b0, r_rearm_band};
        c_plus_trip = {1'b0, r_axis_center} + {2'b0, r_trip_distance};
        ax_hit      = 1'b0;
        ax_idx      = '0;
        ax_dir      = DIR_PLUS;
        ax_armed    = r_armed;
        v_ext       = '0;
        v_plus_band = '0;
        v_plus_trip = '0;
        arm_now     = 1'b0;
        for (int i = 0; i < AXIS_COUNT; i++) begin
            v_ext       = {1'b0, r_axis[i]};
            v_plus_band = v_ext + {2'b0, r_rearm_band};
            v_plus_trip = v_ext + {2'b0, r_trip_distance};
            arm_now     = r_armed[i] ||
                          ((v_plus_band > {1'b0, r_axis_center}) && (v_ext < c_plus_band));
            if (!ax_hit) begin
                ax_armed[i] = arm_now;
                if (arm_now && (v_ext > c_plus_trip)) begin
                    ax_hit      = 1'b1;
                    ax_idx      = INDEX_W'(i);
                    ax_dir      = DIR_PLUS;
                    ax_armed[i] = 1'b0;
                end else if (arm_now && (v_plus_trip < {1'b0, r_axis_center})) begin
                    ax_hit      = 1'b1;
                    ax_idx      = INDEX_W'(i);
                    ax_dir      = DIR_MINUS;
                    ax_armed[i] = 1'b0;
                end
            end
        end
    end

    // final priority select
    logic [KIND_W-1:0]     n_out_kind;
    logic [INDEX_W-1:0]    n_out_index;
    logic [DIR_W-1:0]      n_out_dir;
    logic [AXIS_COUNT-1:0] n_armed;

    always_comb begin
        n_out_kind  = KIND_NONE;
        n_out_index = '0;
        n_out_dir   = '0;
        n_armed     = r_armed;
        if (r_in_sv) begin
            if (btn_hit) begin
                n_out_kind  = KIND_BUTTON;
                n_out_index = btn_idx;
            end else if (hat_hit) begin
                n_out_kind  = KIND_HAT;
                n_out_index = hat_idx;
                n_out_dir   = hat_dir;
            end else begin
                n_armed = ax_armed;
                if (ax_hit) begin
                    n_out_kind  = KIND_AXIS;
                    n_out_index = ax_idx;
                    n_out_dir   = ax_dir;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_armed   <= '0;
        end else begin
            if (adv) begin
                r_out_vld <= 1'b1;
                r_armed   <= n_armed;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_kind  <= n_out_kind;
            r_out_index <= n_out_index;
            r_out_dir   <= n_out_dir;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_dir, r_out_index};
    assign m_axis_tuser  = r_out_kind;

    // an invalid sample leaves the arm flags alone
    a_invalid_keeps_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !r_in_sv |=> $stable(r_armed))
        else $error("arm flags changed on invalid sample");

    // a fired axis is disarmed
    a_fire_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && (n_out_kind == KIND_AXIS) |=> !r_armed[r_out_index[2:0]])
        else $error("fired axis still armed");

    // a button or hat event leaves the arm flags alone
    a_early_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && ((n_out_kind == KIND_BUTTON) || (n_out_kind == KIND_HAT))
        |=> $stable(r_armed))
        else $error("arm flags changed on button or hat event");

    // a held input beat is not dropped
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !adv |=> r_in_vld)
        else $error("input beat dropped");

endmodule : gamepad_control_event_detector_top
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the gamepad control event detector against a cycle-free predictor
// of the priority decode (buttons, hats, then axes with re-arm hysteresis).
// Directed cases cover the priority order, count clamping, the exact hat
// angles, strict trip and band edges and the slider two band. Random
// traffic follows, in phases with different register settings.
// ----------------------------------------------------------------------------
module testbench;
    import gced_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int MAX_BUTTONS     = 64;
    localparam int MAX_HATS        = 4;
    localparam int SETTLE_CYCLES   = 4;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int BTN_CNT_MAX     = (1 << BTN_CNT_W) - 1;
    localparam int HAT_CNT_MAX     = (1 << HAT_CNT_W) - 1;
    localparam int BAND_MAX        = (1 << BAND_W) - 1;
    localparam int AXIS_MAX        = (1 << AXIS_W) - 1;

    localparam logic [HAT_W-1:0] HAT_CENTERED = 16'hffff;
    localparam logic [3:0][HAT_W-1:0] HAT_DIRS = {ANG_LEFT, ANG_DOWN, ANG_RIGHT, ANG_UP};

    typedef struct packed {
        logic                              valid;
        logic [63:0]                       buttons;
        logic [63:0]                       hats;
        logic [AXIS_COUNT-1:0][AXIS_W-1:0] axes;
    } t_sample;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] index;
        logic [DIR_W-1:0]   dir;
    } t_event;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} t_rx_mode;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]     m_axis_tuser;

    // predictor copy of registers and arm flags
    logic [BTN_CNT_W-1:0]  cfg_buttons;
    logic [HAT_CNT_W-1:0]  cfg_hats;
    logic [AXIS_W-1:0]     cfg_center;
    logic [BAND_W-1:0]     cfg_band;
    logic [BAND_W-1:0]     cfg_trip;
    logic [AXIS_COUNT-1:0] armed;

    t_event   pending_events[$];
    t_event   want;
    int       error_count  = 0;
    int       results_seen = 0;
    int       burst_left   = 0;
    int       cycle_count  = 0;
    int       rx_tick      = 0;
    t_rx_mode rx_mode      = RX_OPEN;

    gamepad_control_event_detector_top #(
        .MAX_BUTTONS(MAX_BUTTONS),
        .MAX_HATS   (MAX_HATS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_event detect_event(t_sample s);
        t_event           ev;
        int               i, limit, c, band, trip, v;
        logic [HAT_W-1:0] ang;
        logic             hit;
        ev = '0;
        if (!s.valid) return ev;

        limit = (cfg_buttons > MAX_BUTTONS) ? MAX_BUTTONS : cfg_buttons;
        for (i = 0; i < limit; i++) begin
            if (s.buttons[i]) begin
                ev.kind  = KIND_BUTTON;
                ev.index = INDEX_W'(i);
                return ev;
            end
        end

        limit = (cfg_hats > MAX_HATS) ? MAX_HATS : cfg_hats;
        for (i = 0; i < limit; i++) begin
            ang = s.hats[HAT_W*i +: HAT_W];
            hit = 1'b1;
            case (ang)
                ANG_UP:    ev.dir = DIR_UP;
                ANG_RIGHT: ev.dir = DIR_RIGHT;
                ANG_DOWN:  ev.dir = DIR_DOWN;
                ANG_LEFT:  ev.dir = DIR_LEFT;
                default:   hit = 1'b0;
            endcase
            if (hit) begin
                ev.kind  = KIND_HAT;
                ev.index = INDEX_W'(i);
                return ev;
            end
        end

        c    = cfg_center;
        band = cfg_band;
        trip = cfg_trip;
        for (i = 0; i < AXIS_COUNT; i++) begin
            v = s.axes[i];
            if (v > c - band && v < c + band) armed[i] = 1'b1;
            if (armed[i] && (v > c + trip || v < c - trip)) begin
                armed[i] = 1'b0;
                ev.kind  = KIND_AXIS;
                ev.index = INDEX_W'(i);
                ev.dir   = (v > c + trip) ? DIR_PLUS : DIR_MINUS;
                return ev;
            end
        end
        return ev;
    endfunction

    task report_error(string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_events.size() == 0) begin
                report_error($sformatf("result %0d with no event pending", results_seen));
            end else begin
                want = pending_events.pop_front();
                if (m_axis_tuser !== want.kind)
                    report_error($sformatf("result %0d kind %0d, expected %0d",
                                           results_seen, m_axis_tuser, want.kind));
                if (m_axis_tdata[INDEX_W-1:0] !== want.index)
                    report_error($sformatf("result %0d index %0d, expected %0d",
                                           results_seen, m_axis_tdata[INDEX_W-1:0], want.index));
                if (m_axis_tdata[INDEX_W +: DIR_W] !== want.dir)
                    report_error($sformatf("result %0d direction %0d, expected %0d",
                                           results_seen, m_axis_tdata[INDEX_W +: DIR_W],
                                           want.dir));
            end
            results_seen++;
        end
    end

    // receiver backpressure, switching at random between open, coin, periodic and sparse modes
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 96 == 0) rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:     m_axis_tready <= 1'b1;
            RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: m_axis_tready <= (rx_tick % 5) != 0;
            default:     m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic apply_reset();
        cfg_buttons = '0;
        cfg_hats    = '0;
        cfg_center  = CENTER_RST;
        cfg_band    = BAND_RST;
        cfg_trip    = TRIP_RST;
        armed       = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // drop valid, wait for every pending result, then let the pipe settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_BUTTON_COUNT:  cfg_buttons = data[BTN_CNT_W-1:0];
            CFG_HAT_COUNT:     cfg_hats    = data[HAT_CNT_W-1:0];
            CFG_AXIS_CENTER:   cfg_center  = data;
            CFG_REARM_BAND:    cfg_band    = data[BAND_W-1:0];
            CFG_TRIP_DISTANCE: cfg_trip    = data[BAND_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_sample(t_sample s);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {s.axes, s.hats, s.buttons};
        s_axis_tuser  <= s.valid;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_events.push_back(detect_event(s));
    endtask

    function automatic t_sample centered_sample();
        t_sample s;
        s.valid   = 1'b1;
        s.buttons = '0;
        s.hats    = {MAX_HATS{HAT_CENTERED}};
        s.axes    = {AXIS_COUNT{cfg_center}};
        return s;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] with_noise(int value, int width);
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom);
        word = (word >> width << width) | CFG_DATA_W'(value);
        return word;
    endfunction

    // axis position aimed at the band and trip edges of the current setting
    function automatic logic [AXIS_W-1:0] axis_value(logic near_only);
        int c, band, trip, span, v;
        c    = cfg_center;
        band = cfg_band;
        trip = cfg_trip;
        span = (band > 1) ? 2 * band - 2 : 0;
        case (near_only ? 0 : $urandom_range(0, 9))
            0, 1, 2: v = c - band + 1 + int'($urandom_range(0, span));
            3:       v = c + trip + 1 + int'($urandom_range(0, 2000));
            4:       v = c - trip - 1 - int'($urandom_range(0, 2000));
            5: begin
                case ($urandom_range(0, 7))
                    0: v = c - band;
                    1: v = c + band;
                    2: v = c - band + 1;
                    3: v = c + band - 1;
                    4: v = c + trip;
                    5: v = c + trip + 1;
                    6: v = c - trip;
                    default: v = c - trip - 1;
                endcase
            end
            6:       v = ($urandom_range(0, 1) != 0) ? AXIS_MAX : 0;
            default: v = $urandom_range(0, AXIS_MAX);
        endcase
        if (v < 0) v = 0;
        if (v > AXIS_MAX) v = AXIS_MAX;
        return AXIS_W'(v);
    endfunction

    function automatic t_sample random_sample();
        t_sample s;
        int      i, focus;
        s.valid = ($urandom_range(0, 15) != 0);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: s.buttons = '0;
            6: s.buttons = 64'd1 << $urandom_range(0, 63);
            7: s.buttons = {$urandom, $urandom} << cfg_buttons;  // only absent buttons
            8: s.buttons = {$urandom, $urandom};
            default: s.buttons = '1;
        endcase
        for (i = 0; i < MAX_HATS; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: s.hats[HAT_W*i +: HAT_W] = HAT_CENTERED;
                6: s.hats[HAT_W*i +: HAT_W] = HAT_DIRS[$urandom_range(0, 3)];
                7: s.hats[HAT_W*i +: HAT_W] = HAT_DIRS[$urandom_range(0, 3)] +
                       (($urandom_range(0, 1) != 0) ? 16'd1 : 16'hffff);
                default: s.hats[HAT_W*i +: HAT_W] = HAT_W'($urandom);
            endcase
        end
        // axes ahead of the focus mostly rest inside the band so deeper axes get examined
        focus = $urandom_range(0, AXIS_COUNT - 1);
        for (i = 0; i < AXIS_COUNT; i++)
            s.axes[i] = axis_value(i < focus && $urandom_range(0, 6) != 0);
        return s;
    endfunction

    task automatic test_reset_state();
        t_sample s;
        s = centered_sample();
        s.buttons = '1;
        s.hats    = '0;     // all hats at up, but none present yet
        send_sample(s);
        s = centered_sample();
        s.valid   = 1'b0;
        s.axes[0] = '1;
        send_sample(s);
        s.valid = 1'b1;
        send_sample(s);
    endtask

    task automatic test_button_priority();
        t_sample s;
        write_reg(CFG_BUTTON_COUNT, 16'd64);
        write_reg(CFG_HAT_COUNT, 16'd4);
        s = centered_sample();
        s.hats    = '0;
        s.buttons = 64'd1 << 63;
        send_sample(s);
        s.buttons = '1;
        send_sample(s);
        write_reg(CFG_BUTTON_COUNT, 16'hff7f);   // 127 once masked, clamps to the maximum
        s.buttons = 64'd1 << 63;
        send_sample(s);
        write_reg(CFG_BUTTON_COUNT, 16'd5);
        s = centered_sample();
        s.buttons = (64'd1 << 5) | (64'd1 << 63);
        send_sample(s);
    endtask

    task automatic test_hat_directions();
        t_sample s;
        s = centered_sample();
        s.hats[HAT_W*1 +: HAT_W] = ANG_RIGHT;
        send_sample(s);
        s = centered_sample();
        s.hats[HAT_W*3 +: HAT_W] = ANG_LEFT;
        send_sample(s);
        s = centered_sample();
        s.hats[HAT_W*0 +: HAT_W] = ANG_DOWN;
        s.hats[HAT_W*1 +: HAT_W] = ANG_UP;
        send_sample(s);
        s = centered_sample();
        s.hats[HAT_W*0 +: HAT_W] = ANG_RIGHT + 16'd1;
        s.hats[HAT_W*2 +: HAT_W] = ANG_UP;
        send_sample(s);
        write_reg(CFG_HAT_COUNT, 16'd7);
        s = centered_sample();
        s.hats[HAT_W*3 +: HAT_W] = ANG_LEFT;
        send_sample(s);
        write_reg(CFG_HAT_COUNT, 16'd2);
        s = centered_sample();
        s.hats[HAT_W*2 +: HAT_W] = ANG_DOWN;
        send_sample(s);
    endtask

    task automatic test_axis_hysteresis();
        t_sample s;
        s = centered_sample();
        send_sample(s);
        s.axes = '0;            // x fires, the rest stay armed
        send_sample(s);
        send_sample(s);         // now y
        s = centered_sample();
        s.axes[0] = '0;
        s.axes[1] = '0;
        s.axes[7] = '1;
        send_sample(s);
        // slider two held at full scale must not fire again until it is centered
        s = centered_sample();
        s.axes[7] = '1;
        send_sample(s);
        s = centered_sample();
        send_sample(s);
        s.axes[7] = '0;
        send_sample(s);
        s = centered_sample();
        s.axes[0] = cfg_center + AXIS_W'(cfg_trip);
        send_sample(s);
        s.axes[0] = cfg_center + AXIS_W'(cfg_trip) + 16'd1;
        send_sample(s);
    endtask

    task automatic test_register_limits();
        t_sample s;
        int      k;
        for (k = int'(CFG_TRIP_DISTANCE) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
        write_reg(CFG_AXIS_CENTER, 16'hffff);
        write_reg(CFG_REARM_BAND, 16'hffff);
        write_reg(CFG_TRIP_DISTANCE, 16'h8000);
        s = centered_sample();
        send_sample(s);
        s.axes[0] = '0;
        send_sample(s);
        write_reg(CFG_REARM_BAND, 16'h8000);    // empty band, nothing re-arms
        s = centered_sample();
        send_sample(s);
        s.axes = '0;
        send_sample(s);
    endtask

    task automatic test_random_traffic();
        int phase, n, hold_at, btn, hats, center, band, trip;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       btn = 0;
                1:       btn = MAX_BUTTONS;
                2:       btn = BTN_CNT_MAX;
                default: btn = ($urandom_range(0, 3) == 0) ?
                               $urandom_range(MAX_BUTTONS + 1, BTN_CNT_MAX) :
                               $urandom_range(0, MAX_BUTTONS);
            endcase
            case (phase)
                0:       hats = 0;
                1:       hats = MAX_HATS;
                2:       hats = HAT_CNT_MAX;
                default: hats = $urandom_range(0, HAT_CNT_MAX);
            endcase
            case (phase)
                3:       center = 0;
                4:       center = AXIS_MAX;
                default: center = ($urandom_range(0, 1) != 0) ? $urandom_range(0, AXIS_MAX) :
                                  $urandom_range(28767, 36767);
            endcase
            case (phase)
                5:       band = 0;
                6:       band = BAND_MAX;
                default: band = $urandom_range(0, 12000);
            endcase
            case (phase)
                7:       trip = 0;
                8:       trip = BAND_MAX;
                default: trip = $urandom_range(0, BAND_MAX);
            endcase
            write_reg(CFG_BUTTON_COUNT, with_noise(btn, BTN_CNT_W));
            write_reg(CFG_HAT_COUNT, with_noise(hats, HAT_CNT_W));
            write_reg(CFG_AXIS_CENTER, CFG_DATA_W'(center));
            write_reg(CFG_REARM_BAND, with_noise(band, BAND_W));
            write_reg(CFG_TRIP_DISTANCE, with_noise(trip, BAND_W));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(int'(CFG_TRIP_DISTANCE) + 1,
                                                    (1 << CFG_IDX_W) - 1)),
                          CFG_DATA_W'($urandom));
            hold_at = $urandom_range(20, ITEMS_PER_PHASE - 20);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == hold_at) wait_idle();
                send_sample(random_sample());
            end
        end
    endtask

    initial begin
        apply_reset();
        test_reset_state();
        test_button_priority();
        test_hat_directions();
        test_axis_hysteresis();
        test_register_limits();
        test_random_traffic();
        wait_idle();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
